[src/dabc_pkg.sv]
// ----------------------------------------------------------------------------
// dabc_pkg: shared types and constants for the depth average core
// Field widths, fixed intrinsics, sequencer codes and the structs that pass
// between the sequencer, the shared multiply-accumulate unit and the divider.
// ----------------------------------------------------------------------------
package dabc_pkg;

  // Sizes
  localparam int MAX_FRAMES = 16;
  localparam int COORD_BITS = 11;
  localparam int COL_W      = 11;
  localparam int DEPTH_W    = 16;
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 20;
  localparam int AVG_W      = 24;
  localparam int PT_W       = 20;
  localparam int CROP_W     = 60;
  localparam int POSE_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DX_W       = 17;
  localparam int TX_W       = 38;
  localparam int XC_W       = 25;
  localparam int MUL_A_W    = 26;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 56;
  localparam int RND_W      = ACC_W - 14;
  localparam int WS_W       = RND_W + 1;
  localparam int DIV_STEPS  = AVG_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [COL_W-1:0] COORD_MASK = COL_W'((1 << COORD_BITS) - 1);

  // Camera intrinsics: centers in 1/16 px, inverse focal lengths scaled by 2^24
  localparam logic signed [DX_W-1:0]    CX16   = 17'sd15257;
  localparam logic signed [DX_W-1:0]    CY16   = 17'sd8522;
  localparam logic signed [MUL_B_W-1:0] INV_FX = 18'sd12138;
  localparam logic signed [MUL_B_W-1:0] INV_FY = 18'sd12162;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT,
    REG_DEPTH_LIMIT,
    REG_POSE_X,
    REG_POSE_Y,
    REG_POSE_Z,
    REG_CROP_BOX
  } reg_idx_t;

  // Payloads
  typedef struct packed {
    logic [COL_W-1:0]   pixel_col;
    logic [COL_W-1:0]   pixel_row;
    logic [DEPTH_W-1:0] depth_sample;
    logic               last_frame;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]       out_col;
    logic [COL_W-1:0]       out_row;
    logic                   in_box;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_DIV,
    ST_ROUND,
    ST_STORE,
    ST_EMIT
  } seq_state_t;

  // Multiply-accumulate program, one code per pass through the multiplier
  typedef enum logic [3:0] {
    OP_LIMIT,
    OP_TX,
    OP_TY,
    OP_XC_LO,
    OP_XC_HI,
    OP_YC_LO,
    OP_YC_HI,
    OP_PX0,
    OP_PX1,
    OP_PX2,
    OP_PY0,
    OP_PY1,
    OP_PY2,
    OP_PZ0,
    OP_PZ1,
    OP_PZ2
  } op_t;

  // Shared multiply-accumulate command
  typedef struct packed {
    logic               mul_en;
    logic               acc_en;
    logic               clear;
    logic               shift20;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mac_cmd_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [AVG_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] quotient;
  } div_rsp_t;

endpackage

[src/dabc_div.sv]
// ----------------------------------------------------------------------------
// dabc_div: restoring divider for the depth average
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module dabc_div (
  input  logic              clk,
  input  logic              rst,
  input  dabc_pkg::div_req_t req,
  output dabc_pkg::div_rsp_t rsp
);
  import dabc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [AVG_W-1:0]     quo;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dvs;
  logic [CNT_W:0]       trial;
  logic                 fits;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem, quo[AVG_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= CNT_W'(trial - {1'b0, dvs});
        quo <= {quo[AVG_W-2:0], 1'b1};
      end else begin
        rem <= trial[CNT_W-1:0];
        quo <= {quo[AVG_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[src/dabc_mac.sv]
// ----------------------------------------------------------------------------
// dabc_mac: shared multiply-accumulate unit
// Registered signed product, then an add into the accumulator, optionally
// with the product shifted up by 20 bits for the high partial product.
// ----------------------------------------------------------------------------
module dabc_mac (
  input  logic                               clk,
  input  dabc_pkg::mac_cmd_t                 cmd,
  output logic signed [dabc_pkg::ACC_W-1:0]  acc
);
  import dabc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  base;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= $signed(cmd.a) * $signed(cmd.b);
    end
  end

  // Accumulate stage
  assign prod_ext = ACC_W'(prod);
  assign addend   = cmd.shift20 ? (prod_ext <<< 20) : prod_ext;
  assign base     = cmd.clear ? '0 : acc;

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc <= base + addend;
    end
  end

endmodule

[src/depth_average_backproject_crop_core.sv]
// ----------------------------------------------------------------------------
// depth_average_backproject_crop_core: depth averaging and crop-box test
// Sums depth samples per pixel, averages on the last one, back-projects
// through fixed intrinsics, applies the configured pose and tests the box.
//
//   channel | signals                            | direction
//   --------+------------------------------------+----------
//   input   | in_valid / in_ready / in_data      | in
//   output  | out_valid / out_ready / out_data   | out
//   config  | cfg_we / cfg_index / cfg_data      | in
//
// A plain sample only adds into the running sum. A last sample runs the
// sequencer: limit product and check, radix-2 divider over 24 quotient bits,
// fifteen multiplier passes with rounding and the output load, before input
// is ready again; a pixel that fails the check skips the divider and passes.
// The result waits in an output register while a new pixel accumulates; the
// sequencer holds in its last state if it is still full. Reset is synchronous.
// ----------------------------------------------------------------------------
module depth_average_backproject_crop_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dabc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dabc_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [dabc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dabc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dabc_pkg::*;

  // Configuration
  logic [CNT_W-1:0]   frame_count;
  logic [DEPTH_W-1:0] depth_limit;
  logic [POSE_W-1:0]  pose_row_x;
  logic [POSE_W-1:0]  pose_row_y;
  logic [POSE_W-1:0]  pose_row_z;
  logic [CROP_W-1:0]  crop_box;

  // Accumulation state
  logic [SUM_W-1:0]   depth_sum;
  logic               zero_seen;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic               in_xfer;

  // Latched pixel
  logic [SUM_W-1:0]   fin_sum;
  logic               fin_zero;
  logic [COL_W-1:0]   pix_col;
  logic [COL_W-1:0]   pix_row;

  // Sequencer
  seq_state_t         state;
  seq_state_t         state_next;
  op_t                op;
  logic               valid_pix;
  logic               pix_ok;
  logic               emit_go;

  // Working values
  logic [CNT_W-1:0]          n;
  logic [AVG_W-1:0]          avg;
  logic [TX_W-1:0]           tx;
  logic [TX_W-1:0]           ty;
  logic signed [XC_W-1:0]    xc;
  logic signed [XC_W-1:0]    yc;
  logic signed [DX_W-1:0]    dx;
  logic signed [DX_W-1:0]    dy;
  logic signed [PT_W-1:0]    px;
  logic signed [PT_W-1:0]    py;
  logic signed [PT_W-1:0]    pz;
  logic signed [RND_W-1:0]   rnd;
  logic signed [RND_W-1:0]   rnd_next;
  logic signed [ACC_W-1:0]   round_sum;
  logic signed [WS_W-1:0]    wsum;
  logic signed [PT_W-1:0]    wsat;
  logic                      xy_round;

  // Shared unit interfaces
  mac_cmd_t                  mac_cmd;
  logic signed [ACC_W-1:0]   acc;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  // Operand decode
  logic [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0] op_b;
  logic               op_first;
  logic               op_end;
  logic               op_sh20;
  logic [POSE_W-1:0]  pose_sel;

  logic               mul_en;
  logic               acc_en;
  logic               div_start;

  out_item_t          out_reg;

  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [WS_W-1:0] v);
    logic signed [WS_W-1:0] hi;
    logic signed [WS_W-1:0] lo;
    hi = WS_W'((1 << (PT_W - 1)) - 1);
    lo = -WS_W'(1 << (PT_W - 1));
    if (v > hi) begin
      sat_pt = PT_W'(hi);
    end else if (v < lo) begin
      sat_pt = PT_W'(lo);
    end else begin
      sat_pt = PT_W'(v);
    end
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= CNT_W'(1);
      depth_limit <= DEPTH_W'(1500);
      pose_row_x  <= '0;
      pose_row_y  <= '0;
      pose_row_z  <= '0;
      crop_box    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_COUNT: frame_count <= cfg_data[CNT_W-1:0];
        REG_DEPTH_LIMIT: depth_limit <= cfg_data[DEPTH_W-1:0];
        REG_POSE_X:      pose_row_x  <= cfg_data[POSE_W-1:0];
        REG_POSE_Y:      pose_row_y  <= cfg_data[POSE_W-1:0];
        REG_POSE_Z:      pose_row_z  <= cfg_data[POSE_W-1:0];
        REG_CROP_BOX:    crop_box    <= cfg_data[CROP_W-1:0];
        default: ;
      endcase
    end
  end

  // Divisor clamped to 1..MAX_FRAMES
  always_comb begin
    if (frame_count == '0) begin
      n = CNT_W'(1);
    end else if (frame_count > CNT_W'(MAX_FRAMES)) begin
      n = CNT_W'(MAX_FRAMES);
    end else begin
      n = frame_count;
    end
  end

  // Input accumulation, saturating sum
  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign sum_wide = (SUM_W + 1)'(depth_sum) + (SUM_W + 1)'(in_data.depth_sample);
  assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_sum <= '0;
      zero_seen <= 1'b0;
    end else if (in_xfer) begin
      if (in_data.last_frame) begin
        depth_sum <= '0;
        zero_seen <= 1'b0;
      end else begin
        depth_sum <= sum_sat;
        zero_seen <= zero_seen || (in_data.depth_sample == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.last_frame) begin
      fin_sum  <= sum_sat;
      fin_zero <= zero_seen || (in_data.depth_sample == '0);
      pix_col  <= in_data.pixel_col & COORD_MASK;
      pix_row  <= in_data.pixel_row & COORD_MASK;
    end
  end

  // Pixel offsets from the principal point, in 1/16 px
  assign dx = $signed({2'b00, pix_col, 4'b0000}) - CX16;
  assign dy = $signed({2'b00, pix_row, 4'b0000}) - CY16;

  // Pose row for the current world-coordinate pass
  always_comb begin
    if (op inside {OP_PX0, OP_PX1, OP_PX2}) begin
      pose_sel = pose_row_x;
    end else if (op inside {OP_PY0, OP_PY1, OP_PY2}) begin
      pose_sel = pose_row_y;
    end else if (op inside {OP_PZ0, OP_PZ1, OP_PZ2}) begin
      pose_sel = pose_row_z;
    end else begin
      pose_sel = '0;
    end
  end

  // Operand select and pass flags
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    op_first = 1'b0;
    op_end   = 1'b0;
    op_sh20  = 1'b0;
    case (op)
      OP_LIMIT: begin
        op_a     = MUL_A_W'(depth_limit);
        op_b     = MUL_B_W'(n);
        op_first = 1'b1;
        op_end   = 1'b1;
      end
      OP_TX: begin
        op_a     = MUL_A_W'(avg);
        op_b     = INV_FX;
        op_first = 1'b1;
        op_end   = 1'b1;
      end
      OP_TY: begin
        op_a     = MUL_A_W'(avg);
        op_b     = INV_FY;
        op_first = 1'b1;
        op_end   = 1'b1;
      end
      OP_XC_LO: begin
        op_a     = MUL_A_W'(tx[19:0]);
        op_b     = MUL_B_W'(dx);
        op_first = 1'b1;
      end
      OP_XC_HI: begin
        op_a     = MUL_A_W'(tx[TX_W-1:20]);
        op_b     = MUL_B_W'(dx);
        op_sh20  = 1'b1;
        op_end   = 1'b1;
      end
      OP_YC_LO: begin
        op_a     = MUL_A_W'(ty[19:0]);
        op_b     = MUL_B_W'(dy);
        op_first = 1'b1;
      end
      OP_YC_HI: begin
        op_a     = MUL_A_W'(ty[TX_W-1:20]);
        op_b     = MUL_B_W'(dy);
        op_sh20  = 1'b1;
        op_end   = 1'b1;
      end
      OP_PX0, OP_PY0, OP_PZ0: begin
        op_a     = MUL_A_W'(xc);
        op_b     = MUL_B_W'($signed(pose_sel[15:0]));
        op_first = 1'b1;
      end
      OP_PX1, OP_PY1, OP_PZ1: begin
        op_a     = MUL_A_W'(yc);
        op_b     = MUL_B_W'($signed(pose_sel[31:16]));
      end
      OP_PX2, OP_PY2, OP_PZ2: begin
        op_a     = MUL_A_W'(avg);
        op_b     = MUL_B_W'($signed(pose_sel[47:32]));
        op_end   = 1'b1;
      end
      default: ;
    endcase
  end

  assign mac_cmd.mul_en  = mul_en;
  assign mac_cmd.acc_en  = acc_en;
  assign mac_cmd.clear   = op_first;
  assign mac_cmd.shift20 = op_sh20;
  assign mac_cmd.a       = op_a;
  assign mac_cmd.b       = op_b;

  dabc_mac u_mac (
    .clk (clk),
    .cmd (mac_cmd),
    .acc (acc)
  );

  assign div_req.start    = div_start;
  assign div_req.dividend = {fin_sum, 4'b0000} + AVG_W'(n >> 1);
  assign div_req.divisor  = n;

  dabc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Limit check against depth_limit * n left in the accumulator
  assign pix_ok = !fin_zero && (fin_sum != '0) &&
                  (ACC_W'(fin_sum) <= $unsigned(acc));

  // Round to nearest, ties away from zero
  assign xy_round  = (op == OP_XC_HI) || (op == OP_YC_HI);
  assign round_sum = acc + (xy_round ? ACC_W'(1 << 27) : ACC_W'(1 << 13))
                     - ACC_W'(acc[ACC_W-1]);
  assign rnd_next  = xy_round ? RND_W'(round_sum >>> 28) : RND_W'(round_sum >>> 14);

  // Add the mm offset in 1/16 mm and saturate
  assign wsum = WS_W'(rnd) + WS_W'($signed({pose_sel[63:48], 4'b0000}));
  assign wsat = sat_pt(wsum);

  assign emit_go = (state == ST_EMIT) && (!out_valid || out_ready);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit strobes
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    acc_en     = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer && in_data.last_frame) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        acc_en = 1'b1;
        if (!op_end) begin
          state_next = ST_MUL;
        end else if (op == OP_LIMIT) begin
          state_next = ST_CHECK;
        end else begin
          state_next = ST_ROUND;
        end
      end
      ST_CHECK: begin
        if (pix_ok) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_MUL;
        end
      end
      ST_ROUND: begin
        state_next = ST_STORE;
      end
      ST_STORE: begin
        state_next = (op == OP_PZ2) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_LIMIT;
    end else begin
      if (state == ST_IDLE) begin
        op <= OP_LIMIT;
      end else if (state == ST_ACC && !op_end) begin
        op <= op_t'(op + 4'd1);
      end else if (state == ST_DIV && div_rsp.done) begin
        op <= OP_TX;
      end else if (state == ST_STORE && op != OP_PZ2) begin
        op <= op_t'(op + 4'd1);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      valid_pix <= pix_ok;
    end
    if (state == ST_DIV && div_rsp.done) begin
      avg <= div_rsp.quotient;
    end
    if (state == ST_ROUND) begin
      rnd <= rnd_next;
    end
    if (state == ST_STORE) begin
      case (op)
        OP_TX:    tx <= acc[TX_W-1:0];
        OP_TY:    ty <= acc[TX_W-1:0];
        OP_XC_HI: xc <= rnd[XC_W-1:0];
        OP_YC_HI: yc <= rnd[XC_W-1:0];
        OP_PX2:   px <= wsat;
        OP_PY2:   py <= wsat;
        OP_PZ2:   pz <= wsat;
        default: ;
      endcase
    end
  end

  // Output register; strict crop box test against 16 * bound
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_reg.out_col <= pix_col;
      out_reg.out_row <= pix_row;
      out_reg.in_box  <= valid_pix &&
        (px > $signed({crop_box[9:0],   4'b0000})) &&
        (px < $signed({crop_box[19:10], 4'b0000})) &&
        (py > $signed({crop_box[29:20], 4'b0000})) &&
        (py < $signed({crop_box[39:30], 4'b0000})) &&
        (pz > $signed({crop_box[49:40], 4'b0000})) &&
        (pz < $signed({crop_box[59:50], 4'b0000}));
      out_reg.point_x <= valid_pix ? px : '0;
      out_reg.point_y <= valid_pix ? py : '0;
      out_reg.point_z <= valid_pix ? pz : '0;
    end
  end

  assign out_data = out_reg;

endmodule
